@@ hw/rtl/wstack_pkg.sv @@
// Package for the word stack: sizes, operation and status codes, word and
// control structs. No dependencies; imported by wstack_ctrl and the top level.
`timescale 1ns / 1ps

package wstack_pkg;

   localparam int unsigned STACK_DEPTH = 1024;
   localparam int unsigned SWAP_REACH  = 15;

   localparam int unsigned LANE_W  = 64;
   localparam int unsigned WORD_W  = 4 * LANE_W;
   localparam int unsigned POS_W   = 10;
   localparam int unsigned DEPTH_W = 11;
   localparam int unsigned ADDR_W  = $clog2(STACK_DEPTH);
   localparam int unsigned COUNT_W = $clog2(STACK_DEPTH + 1);
   localparam int unsigned CMP_W   = (POS_W > COUNT_W) ? POS_W : COUNT_W;

   typedef enum logic [1:0] {
      MODE_PUSH = 2'd0,
      MODE_POP  = 2'd1,
      MODE_SWAP = 2'd2,
      MODE_PEEK = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_OVERFLOW   = 3'd1,
      STATUS_UNDERFLOW  = 3'd2,
      STATUS_SWAP_REACH = 3'd3,
      STATUS_PEEK_RANGE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PEEK_RD,
      ST_SWAP_RD,
      ST_SWAP_WR_TOP,
      ST_SWAP_WR_OTHER,
      ST_FINISH
   } state_type;

   typedef struct packed {
      mode_type          mode;
      logic [LANE_W-1:0] value_lane0;
      logic [LANE_W-1:0] value_lane1;
      logic [LANE_W-1:0] value_lane2;
      logic [LANE_W-1:0] value_lane3;
      logic [POS_W-1:0]  position;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [LANE_W-1:0]  read_lane0;
      logic [LANE_W-1:0]  read_lane1;
      logic [LANE_W-1:0]  read_lane2;
      logic [LANE_W-1:0]  read_lane3;
      logic [DEPTH_W-1:0] depth;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } mem_rd_type;

endpackage

@@ hw/rtl/word_stack_push_pop_swap_peek_unit.sv @@
// Top level of the word stack: sequencer, word RAM and output register.
// Depends on wstack_pkg, wstack_ram and wstack_ctrl.
`timescale 1ns / 1ps

// Bounded stack of 256-bit words (four 64-bit lanes), STACK_DEPTH deep.
// Each request word does push, pop, swap (top with the word 0 to SWAP_REACH
// below it) or peek (position counted from the bottom), and each gives
// exactly one response word with a status code, the peeked word (zero
// otherwise) and the depth after the operation. A failing operation leaves
// the stack untouched. Words live in one simple dual-port RAM (one write,
// one registered read per cycle); the fill count is reset but the RAM is
// not, so there is no clearing pass. One request is worked at a time:
// push, pop and every error go straight to the result stage, peek reads first,
// swap reads top, reads lower, writes both back (one RAM port each way).
// The response sits in an output register, so it may wait on rsp_ready
// while the next request is finished into the sequencer's result stage.

module word_stack_push_pop_swap_peek_unit
   import wstack_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   mem_wr_type        mem_wr;
   mem_rd_type        mem_rd;
   logic [WORD_W-1:0] mem_rdata;

   logic              res_valid;
   logic              slot_free;
   rsp_type           res;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_payload_ff, rsp_payload_in;

   wstack_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req_payload),
      .res_valid (res_valid),
      .res_ready (slot_free),
      .res       (res),
      .mem_wr    (mem_wr),
      .mem_rd    (mem_rd),
      .mem_rdata (mem_rdata)
   );

   wstack_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr.en),
      .wr_addr (mem_wr.addr),
      .wr_data (mem_wr.data),
      .rd_en   (mem_rd.en),
      .rd_addr (mem_rd.addr),
      .rd_data (mem_rdata)
   );

   // output register takes a new word when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (res_valid && slot_free) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ hw/rtl/wstack_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. Generic; no package dependency.
`timescale 1ns / 1ps

module wstack_ram #(
   parameter int unsigned WIDTH = 256,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hw/rtl/wstack_ctrl.sv @@
// Stack sequencer: checks each request against the fill count and drives
// the word RAM through read, modify and write-back. Uses wstack_pkg.
`timescale 1ns / 1ps

module wstack_ctrl
   import wstack_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req,
   output logic              res_valid,
   input  logic              res_ready,
   output rsp_type           res,
   output mem_wr_type        mem_wr,
   output mem_rd_type        mem_rd,
   input  logic [WORD_W-1:0] mem_rdata
);

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] fill_ff, fill_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   status_type         status_ff, status_in;
   logic [WORD_W-1:0]  read_ff, read_in;
   logic [WORD_W-1:0]  top_data_ff, top_data_in;

   logic [ADDR_W-1:0]  top_addr;
   logic [ADDR_W-1:0]  other_addr;
   logic [CMP_W-1:0]   req_pos_cmp;
   logic [CMP_W-1:0]   fill_cmp;

   assign top_addr    = ADDR_W'(fill_ff - COUNT_W'(1));
   assign other_addr  = top_addr - ADDR_W'(pos_ff);
   assign req_pos_cmp = CMP_W'(req.position);
   assign fill_cmp    = CMP_W'(fill_ff);

   assign res.status     = status_ff;
   assign res.read_lane0 = read_ff[LANE_W-1:0];
   assign res.read_lane1 = read_ff[2*LANE_W-1:LANE_W];
   assign res.read_lane2 = read_ff[3*LANE_W-1:2*LANE_W];
   assign res.read_lane3 = read_ff[4*LANE_W-1:3*LANE_W];
   assign res.depth      = DEPTH_W'(fill_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      status_ff   <= status_in;
      read_ff     <= read_in;
      top_data_ff <= top_data_in;
   end

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      pos_in      = pos_ff;
      status_in   = status_ff;
      read_in     = read_ff;
      top_data_in = top_data_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      mem_rd.en   = 1'b0;
      mem_rd.addr = top_addr;
      mem_wr.en   = 1'b0;
      mem_wr.addr = top_addr;
      mem_wr.data = mem_rdata;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               pos_in    = req.position;
               read_in   = '0;
               status_in = STATUS_OK;
               state_in  = ST_FINISH;
               case (req.mode)
                  MODE_PUSH: begin
                     if (fill_ff == COUNT_W'(STACK_DEPTH)) begin
                        status_in = STATUS_OVERFLOW;
                     end else begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = ADDR_W'(fill_ff);
                        mem_wr.data = {req.value_lane3, req.value_lane2,
                                       req.value_lane1, req.value_lane0};
                        fill_in     = fill_ff + COUNT_W'(1);
                     end
                  end
                  MODE_POP: begin
                     if (fill_ff == '0) begin
                        status_in = STATUS_UNDERFLOW;
                     end else begin
                        fill_in = fill_ff - COUNT_W'(1);
                     end
                  end
                  MODE_SWAP: begin
                     if ((req.position > POS_W'(SWAP_REACH)) ||
                         (req_pos_cmp >= fill_cmp)) begin
                        status_in = STATUS_SWAP_REACH;
                     end else begin
                        // fetch top first
                        mem_rd.en   = 1'b1;
                        mem_rd.addr = top_addr;
                        state_in    = ST_SWAP_RD;
                     end
                  end
                  MODE_PEEK: begin
                     if (req_pos_cmp >= fill_cmp) begin
                        status_in = STATUS_PEEK_RANGE;
                     end else begin
                        mem_rd.en   = 1'b1;
                        mem_rd.addr = ADDR_W'(req.position);
                        state_in    = ST_PEEK_RD;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_PEEK_RD: begin
            read_in  = mem_rdata;
            state_in = ST_FINISH;
         end
         ST_SWAP_RD: begin
            // top word arrives; fetch the lower one
            top_data_in = mem_rdata;
            mem_rd.en   = 1'b1;
            mem_rd.addr = other_addr;
            state_in    = ST_SWAP_WR_TOP;
         end
         ST_SWAP_WR_TOP: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = top_addr;
            mem_wr.data = mem_rdata;
            state_in    = ST_SWAP_WR_OTHER;
         end
         ST_SWAP_WR_OTHER: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = other_addr;
            mem_wr.data = top_data_ff;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
